>>> design/lwbg_pkg.sv
// Package for the link wake bounce gate: command, action and refusal codes,
// plus register reset values. No dependencies.
package lwbg_pkg;

  typedef enum logic [1:0] {
    CMD_STEP   = 2'd0,
    CMD_INIT   = 2'd1,
    CMD_REOPEN = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_EXHAUSTED = 2'd1,
    ACT_BOUNCE    = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    RF_OK              = 4'd0,
    RF_NOT_PROBING     = 4'd1,
    RF_NO_CARRIER      = 4'd2,
    RF_CARRIER_UNKNOWN = 4'd3,
    RF_BOX_TALKING     = 4'd4,
    RF_NOTHING_SENT    = 4'd5,
    RF_SIBLING         = 4'd6,
    RF_SPENT           = 4'd7,
    RF_SETTLING        = 4'd8,
    RF_PUSH_UNPROVEN   = 4'd9
  } refusal_t;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_BOUNCES = 2'd0;
  localparam logic [1:0] REG_SETTLE_TIME = 2'd1;
  localparam logic [1:0] REG_GRACE_TIME  = 2'd2;
  localparam logic [1:0] REG_MIN_PUSHES  = 2'd3;

  localparam logic [7:0]  MAX_BOUNCES_RST = 8'd3;
  localparam logic [39:0] SETTLE_TIME_RST = 40'd5000000000;
  localparam logic [39:0] GRACE_TIME_RST  = 40'd10000000000;
  localparam logic [15:0] MIN_PUSHES_RST  = 16'd1;

endpackage

>>> design/link_wake_bounce_gate.sv
// Link wake bounce gate: input register, refusal ladder and state update,
// result register. Depends on lwbg_pkg.
//
// A transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle while out_stall does not hold the result
// register; the state loop closes on each commit into the result register.
// Reset (rst, synchronous): clears gate state and pipeline valids, loads the
// configuration registers with their defaults.
module link_wake_bounce_gate (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [63:0] now_time_ns,
  input  logic        is_probing,
  input  logic signed [1:0] carrier_state,
  input  logic [31:0] far_frames_seen,
  input  logic [31:0] own_frames_sent,
  input  logic        siblings_busy,
  input  logic [31:0] pushes_done,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  action,
  output logic [3:0]  refusal_code,
  output logic        say_refusal
);
  import lwbg_pkg::*;

  // configuration
  logic [7:0]  max_bounces;
  logic [39:0] settle_time_ns;
  logic [39:0] grace_time_ns;
  logic [15:0] min_pushes;

  // gate state
  logic [63:0] opened_time, opened_time_next;
  logic [63:0] last_bounce_time, last_bounce_time_next;
  logic [7:0]  bounce_count, bounce_count_next;
  refusal_t    current_refusal, current_refusal_next;
  refusal_t    reported_refusal, reported_refusal_next;
  logic        exhausted_told, exhausted_told_next;

  // input register
  logic        s1_valid;
  cmd_t        s1_command;
  logic [63:0] s1_now;
  logic        s1_probing;
  logic [1:0]  s1_carrier;
  logic        s1_far_zero;
  logic        s1_own_zero;
  logic        s1_siblings;
  logic [31:0] s1_pushes;

  action_t     act_next;
  logic        say_next;
  logic        out_free;
  logic        commit;
  logic [63:0] since_bounce;
  logic [63:0] since_open;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign commit   = s1_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bounces    <= MAX_BOUNCES_RST;
      settle_time_ns <= SETTLE_TIME_RST;
      grace_time_ns  <= GRACE_TIME_RST;
      min_pushes     <= MIN_PUSHES_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_BOUNCES: max_bounces    <= cfg_data[7:0];
        REG_SETTLE_TIME: settle_time_ns <= cfg_data;
        REG_GRACE_TIME:  grace_time_ns  <= cfg_data;
        REG_MIN_PUSHES:  min_pushes     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // fold the frame counters to the single facts the ladder needs; pushes pass whole
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_command  <= cmd_t'(command);
      s1_now      <= now_time_ns;
      s1_probing  <= is_probing;
      s1_carrier  <= carrier_state;
      s1_far_zero <= (far_frames_seen == 32'd0);
      s1_own_zero <= (own_frames_sent == 32'd0);
      s1_siblings <= siblings_busy;
      s1_pushes   <= pushes_done;
    end
  end

  // time differences wrap modulo 2^64
  assign since_bounce = s1_now - last_bounce_time;
  assign since_open   = s1_now - opened_time;

  always_comb begin
    opened_time_next      = opened_time;
    last_bounce_time_next = last_bounce_time;
    bounce_count_next     = bounce_count;
    current_refusal_next  = current_refusal;
    reported_refusal_next = reported_refusal;
    exhausted_told_next   = exhausted_told;
    act_next              = ACT_NONE;
    say_next              = 1'b0;
    case (s1_command)
      CMD_STEP: begin
        if (!s1_probing) begin
          current_refusal_next = RF_NOT_PROBING;
        end else if (s1_carrier == 2'b00) begin
          current_refusal_next = RF_NO_CARRIER;
        end else if (s1_carrier[1]) begin
          // any negative carrier pattern reads as unknown
          current_refusal_next = RF_CARRIER_UNKNOWN;
        end else if (!s1_far_zero) begin
          current_refusal_next = RF_BOX_TALKING;
        end else if (s1_own_zero) begin
          current_refusal_next = RF_NOTHING_SENT;
        end else if (s1_siblings) begin
          current_refusal_next = RF_SIBLING;
        end else if (bounce_count >= max_bounces) begin
          current_refusal_next = RF_SPENT;
          if (!exhausted_told) begin
            exhausted_told_next = 1'b1;
            act_next            = ACT_EXHAUSTED;
          end
        end else if (bounce_count != 8'd0 &&
                     since_bounce < {24'd0, settle_time_ns}) begin
          current_refusal_next = RF_SETTLING;
        end else if (s1_pushes < {16'd0, min_pushes} ||
                     since_open < {24'd0, grace_time_ns}) begin
          current_refusal_next = RF_PUSH_UNPROVEN;
        end else begin
          current_refusal_next  = RF_OK;
          bounce_count_next     = bounce_count + 8'd1;
          last_bounce_time_next = s1_now;
          act_next              = ACT_BOUNCE;
        end
      end
      CMD_INIT: begin
        opened_time_next      = s1_now;
        last_bounce_time_next = 64'd0;
        bounce_count_next     = 8'd0;
        current_refusal_next  = RF_OK;
        reported_refusal_next = RF_OK;
        exhausted_told_next   = 1'b0;
      end
      CMD_REOPEN: begin
        opened_time_next      = s1_now;
        current_refusal_next  = RF_OK;
        reported_refusal_next = RF_OK;
      end
      CMD_REPORT: begin
        if (current_refusal != RF_OK && current_refusal != reported_refusal) begin
          reported_refusal_next = current_refusal;
          say_next              = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      opened_time      <= 64'd0;
      last_bounce_time <= 64'd0;
      bounce_count     <= 8'd0;
      current_refusal  <= RF_OK;
      reported_refusal <= RF_OK;
      exhausted_told   <= 1'b0;
    end else if (commit) begin
      opened_time      <= opened_time_next;
      last_bounce_time <= last_bounce_time_next;
      bounce_count     <= bounce_count_next;
      current_refusal  <= current_refusal_next;
      reported_refusal <= reported_refusal_next;
      exhausted_told   <= exhausted_told_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      action       <= act_next;
      refusal_code <= current_refusal_next;
      say_refusal  <= say_next;
    end
  end

endmodule
